>>> sv/cds_pkg.sv
package cds_pkg;

	localparam int RND_W     = 16;
	localparam int REQ_W     = 2;
	localparam int CODE_W    = 6;
	localparam int RANK_W    = 4;
	localparam int SUIT_W    = 2;
	localparam int CARDS_W   = 6;
	localparam int RANK_CNT  = 13;
	localparam int SUIT_CNT  = 4;
	localparam int SUIT_STEPS = ((2 ** CODE_W) - 1) / RANK_CNT;

	localparam int MOD_BPC   = 4;
	localparam int MOD_STEPS = RND_W / MOD_BPC;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	typedef enum logic [REQ_W-1:0] {
		OP_REFILL  = 2'd0,
		OP_SHUFFLE = 2'd1,
		OP_DRAW    = 2'd2,
		OP_STATUS  = 2'd3
	} req_op_t;

	typedef struct packed {
		req_op_t          op;
		logic [RND_W-1:0] rnd;
	} cmd_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [SUIT_W-1:0] suit;
	} card_t;

	// code -> rank/suit by repeated subtraction of the rank count
	function automatic card_t card_split(input logic [CODE_W-1:0] code);
		card_t              c;
		logic [CODE_W-1:0]  r;
		logic [SUIT_W-1:0]  s;
		r = code;
		s = '0;
		for (int i = 0; i < SUIT_STEPS; i++) begin
			if (r >= CODE_W'(RANK_CNT)) begin
				r = r - CODE_W'(RANK_CNT);
				s = s + SUIT_W'(1);
			end
		end
		c.rank = r[RANK_W-1:0];
		c.suit = s;
		return c;
	endfunction

endpackage

>>> sv/cds_req_if.sv
interface cds_req_if;
	logic                       valid;
	logic                       ready;
	logic [cds_pkg::REQ_W-1:0]  req_type;
	logic [cds_pkg::RND_W-1:0]  random_word;

	modport source(output valid, output req_type, output random_word, input ready);
	modport sink(input valid, input req_type, input random_word, output ready);
endinterface

>>> sv/cds_rsp_if.sv
interface cds_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [cds_pkg::RANK_W-1:0]   card_rank;
	logic [cds_pkg::SUIT_W-1:0]   card_suit;
	logic                         deck_empty;
	logic                         shuffle_done;
	logic [cds_pkg::CARDS_W-1:0]  cards_left;

	modport source(output valid, output card_rank, output card_suit, output deck_empty,
		output shuffle_done, output cards_left, input ready);
	modport sink(input valid, input card_rank, input card_suit, input deck_empty,
		input shuffle_done, input cards_left, output ready);
endinterface

>>> sv/cds_ram.sv
module cds_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 52
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/cds_mod.sv
module cds_mod #(
	parameter int DW = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cds_pkg::RND_W-1:0] dividend,
	input  logic [DW-1:0]             divisor,
	output logic                      done,
	output logic [DW-1:0]             rem
);

	logic [DW-1:0]                  rem_q;
	logic [cds_pkg::RND_W-1:0]      dvd_q;
	logic [DW-1:0]                  div_q;
	logic [cds_pkg::MOD_CNT_W-1:0]  cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [DW-1:0]                  r;
	logic [DW:0]                    t;
	logic [DW-1:0]                  rem_next;

	// restoring remainder, MOD_BPC dividend bits per cycle
	always_comb begin
		r = rem_q;
		t = '0;
		for (int i = 0; i < cds_pkg::MOD_BPC; i++) begin
			t = {r, dvd_q[cds_pkg::RND_W-1-i]};
			if (t >= {1'b0, div_q}) begin
				r = DW'(t - {1'b0, div_q});
			end else begin
				r = t[DW-1:0];
			end
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cds_pkg::MOD_CNT_W'(cds_pkg::MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= dvd_q << cds_pkg::MOD_BPC;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("remainder not below divisor");

endmodule

>>> sv/cds_front.sv
module cds_front (
	input  logic            clk,
	input  logic            arst_n,
	cds_req_if.sink         req,
	output cds_pkg::cmd_t   cmd,
	output logic            cmd_avail,
	input  logic            cmd_pop
);

	cds_pkg::cmd_t                  fifo_q [cds_pkg::Q_DEPTH];
	logic [cds_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [cds_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [cds_pkg::Q_CNT_W-1:0]    cnt_q;
	cds_pkg::cmd_t                  dec;
	logic                           push;

	always_comb begin
		dec.rnd = req.random_word;
		case (req.req_type)
			cds_pkg::OP_REFILL:  dec.op = cds_pkg::OP_REFILL;
			cds_pkg::OP_SHUFFLE: dec.op = cds_pkg::OP_SHUFFLE;
			cds_pkg::OP_DRAW:    dec.op = cds_pkg::OP_DRAW;
			default:             dec.op = cds_pkg::OP_STATUS;
		endcase
	end

	assign req.ready = (cnt_q != cds_pkg::Q_CNT_W'(cds_pkg::Q_DEPTH));
	assign push      = req.valid && req.ready;
	assign cmd_avail = (cnt_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (cnt_q != '0))
		else $error("pop from empty queue");

endmodule

>>> sv/cds_back.sv
module cds_back #(
	parameter int DECK_SIZE = 52
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cds_pkg::cmd_t   cmd,
	input  logic            cmd_avail,
	output logic            cmd_pop,
	cds_rsp_if.source       rsp
);

	localparam int IDX_W = $clog2(DECK_SIZE);
	localparam int CNT_W = $clog2(DECK_SIZE + 1);
	localparam int DW    = IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(DECK_SIZE - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DECK_SIZE);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MOD   = 6'b000010,
		ST_SWAP1 = 6'b000100,
		ST_SWAP2 = 6'b001000,
		ST_DRAW  = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               remaining_q;
	logic [IDX_W-1:0]               pos_q;
	logic                           finished_q;
	logic [DECK_SIZE-1:0]           valid_q;
	logic                           out_valid_q;
	logic [IDX_W-1:0]               rd_addr_q;
	logic [cds_pkg::CODE_W-1:0]     a_q;
	logic [IDX_W-1:0]               other_q;
	logic [cds_pkg::RANK_W-1:0]     rank_q;
	logic [cds_pkg::SUIT_W-1:0]     suit_q;
	logic                           empty_q;
	logic [cds_pkg::RANK_W-1:0]     rsp_rank_q;
	logic [cds_pkg::SUIT_W-1:0]     rsp_suit_q;
	logic                           rsp_empty_q;
	logic                           rsp_done_q;
	logic [cds_pkg::CARDS_W-1:0]    rsp_left_q;

	logic                           start;
	logic                           ram_we;
	logic [IDX_W-1:0]               ram_waddr;
	logic [cds_pkg::CODE_W-1:0]     ram_wdata;
	logic                           ram_re;
	logic [IDX_W-1:0]               ram_raddr;
	logic [cds_pkg::CODE_W-1:0]     ram_rdata;
	logic [cds_pkg::CODE_W-1:0]     rd_code;
	logic [CNT_W-1:0]               draw_cnt;
	logic                           mod_start;
	logic                           mod_done;
	logic [DW-1:0]                  mod_rem;
	logic [DW-1:0]                  divisor;
	cds_pkg::card_t                 card;

	cds_ram #(
		.WIDTH (cds_pkg::CODE_W),
		.DEPTH (DECK_SIZE)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cds_mod #(
		.DW (DW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (cmd.rnd),
		.divisor  (divisor),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// slot never written since refill holds its own index
	assign rd_code  = valid_q[rd_addr_q] ? ram_rdata : cds_pkg::CODE_W'(rd_addr_q);
	assign draw_cnt = remaining_q - 1'b1;
	assign divisor  = {1'b0, pos_q} + DW'(1);
	assign start    = (state_q == ST_IDLE) && cmd_avail && !out_valid_q;
	assign cmd_pop  = start;
	assign card     = cds_pkg::card_split(rd_code);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = pos_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = rd_code;
		mod_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start && cmd.op == cds_pkg::OP_SHUFFLE && !finished_q) begin
					ram_re    = 1'b1;
					mod_start = 1'b1;
				end
				if (start && cmd.op == cds_pkg::OP_DRAW && remaining_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = draw_cnt[IDX_W-1:0];
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					ram_re    = 1'b1;
					ram_raddr = mod_rem[IDX_W-1:0];
				end
			end
			ST_SWAP1: begin
				ram_we = 1'b1;
			end
			ST_SWAP2: begin
				ram_we    = 1'b1;
				ram_waddr = other_q;
				ram_wdata = a_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			remaining_q <= FULL;
			pos_q       <= LAST;
			finished_q  <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESP) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (cmd.op)
							cds_pkg::OP_REFILL: begin
								valid_q     <= '0;
								remaining_q <= FULL;
								pos_q       <= LAST;
								finished_q  <= 1'b0;
								state_q     <= ST_RESP;
							end
							cds_pkg::OP_SHUFFLE: begin
								state_q <= finished_q ? ST_RESP : ST_MOD;
							end
							cds_pkg::OP_DRAW: begin
								if (remaining_q == '0) begin
									state_q <= ST_RESP;
								end else begin
									remaining_q <= draw_cnt;
									state_q     <= ST_DRAW;
								end
							end
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_SWAP1;
					end
				end
				ST_SWAP1: begin
					valid_q[pos_q] <= 1'b1;
					state_q        <= ST_SWAP2;
				end
				ST_SWAP2: begin
					valid_q[other_q] <= 1'b1;
					if (pos_q == '0) begin
						finished_q <= 1'b1;
					end else begin
						pos_q <= pos_q - 1'b1;
					end
					state_q <= ST_RESP;
				end
				ST_DRAW: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_addr_q <= ram_raddr;
		end
		if (start) begin
			rank_q  <= '0;
			suit_q  <= '0;
			empty_q <= (cmd.op == cds_pkg::OP_DRAW) && (remaining_q == '0);
		end
		if (state_q == ST_MOD && mod_done) begin
			a_q     <= rd_code;
			other_q <= mod_rem[IDX_W-1:0];
		end
		if (state_q == ST_DRAW) begin
			rank_q <= card.rank;
			suit_q <= card.suit;
		end
		if (state_q == ST_RESP) begin
			rsp_rank_q  <= rank_q;
			rsp_suit_q  <= suit_q;
			rsp_empty_q <= empty_q;
			rsp_done_q  <= finished_q;
			rsp_left_q  <= cds_pkg::CARDS_W'(remaining_q);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.card_rank    = rsp_rank_q;
	assign rsp.card_suit    = rsp_suit_q;
	assign rsp.deck_empty   = rsp_empty_q;
	assign rsp.shuffle_done = rsp_done_q;
	assign rsp.cards_left   = rsp_left_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST)
		else $error("shuffle position out of range");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		remaining_q <= FULL)
		else $error("card count above deck size");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) |-> !out_valid_q)
		else $error("result register overwritten");

endmodule

>>> sv/card_deck_shuffle_draw.sv
// Card deck with refill, one-swap-per-request shuffle and draw. Requests enter a
// two-entry queue and are carried out one at a time against a DECK_SIZE-slot
// store with one read and one write port; one result transaction per request.
// A shuffle swap first runs the remainder unit (4 random bits per cycle), then
// makes two store reads and two store writes on the single port pair. Slots not
// written since reset or refill read as their index, so there is no clearing pass.
module card_deck_shuffle_draw #(
	parameter int DECK_SIZE = 52
) (
	input  logic        clk,
	input  logic        arst_n,
	cds_req_if.sink     req,
	cds_rsp_if.source   rsp
);

	cds_pkg::cmd_t cmd;
	logic          cmd_avail;
	logic          cmd_pop;

	cds_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_avail (cmd_avail),
		.cmd_pop   (cmd_pop)
	);

	cds_back #(
		.DECK_SIZE (DECK_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_avail (cmd_avail),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);

endmodule
